FILE: rtl/core/pwg_pkg.sv
// Package for the PWM waveform generator: widths, command and status codes,
// controller/datapath handshake structs and the sine lookup function.
// Has no dependencies; every other file of the block imports it.
package pwg_pkg;

  // Field widths.
  localparam int BYTE_W   = 8;
  localparam int WAVE_W   = 2;
  localparam int FREQ_W   = 10;
  localparam int STATUS_W = 2;
  localparam int LIMIT_W  = 7;
  localparam int PWM_W    = 8;

  // Timing constants.
  localparam int PWM_TOP         = 255;
  localparam int SAMPLES_DEFAULT = 256;
  localparam int TIMER_CLOCK     = 72000000;
  localparam int FREQ_MIN        = 10;
  localparam int FREQ_MAX        = 1000;
  localparam int FREQ_STEP       = 10;
  localparam int FREQ_RESET      = 100;
  localparam int LIMIT_RESET     = 10;
  localparam int LIMIT_MAX       = 127;

  // The divider produces one more quotient bit than the limit holds,
  // so that a quotient of 128 or more shows as saturated.
  localparam int QUOT_W = LIMIT_W + 1;
  localparam int STEP_W = $clog2(QUOT_W);

  // Command bytes.
  localparam logic [BYTE_W-1:0] CMD_SINE     = 8'h31;
  localparam logic [BYTE_W-1:0] CMD_SAWTOOTH = 8'h34;
  localparam logic [BYTE_W-1:0] CMD_FREQ_UP  = 8'h2B;
  localparam logic [BYTE_W-1:0] CMD_FREQ_DN  = 8'h2D;

  // Operation codes of an input item.
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_COMMAND = 1'b1;

  // Waveform codes.
  localparam logic [WAVE_W-1:0] SHAPE_SINE     = 2'd0;
  localparam logic [WAVE_W-1:0] SHAPE_SQUARE   = 2'd1;
  localparam logic [WAVE_W-1:0] SHAPE_TRIANGLE = 2'd2;
  localparam logic [WAVE_W-1:0] SHAPE_RAMP     = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_LIMIT   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNKNOWN = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic apply;       // accepted transaction: update state from the input item
    logic div_load;    // start the prescaler division
    logic div_step;    // one quotient bit
    logic div_finish;  // write the new prescale limit
  } pwg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic freq_change; // the waiting item is a frequency step that takes effect
  } pwg_stat_t;

  // First quarter of the sine table, 65 points.
  localparam logic [7:0] QUARTER_SINE [65] = '{
    8'd127, 8'd130, 8'd133, 8'd136, 8'd139, 8'd143, 8'd146, 8'd149, 8'd152,
    8'd155, 8'd158, 8'd161, 8'd164, 8'd167, 8'd170, 8'd173, 8'd176, 8'd179,
    8'd182, 8'd184, 8'd187, 8'd190, 8'd193, 8'd195, 8'd198, 8'd200, 8'd203,
    8'd205, 8'd208, 8'd210, 8'd213, 8'd215, 8'd217, 8'd219, 8'd221, 8'd224,
    8'd226, 8'd228, 8'd229, 8'd231, 8'd233, 8'd235, 8'd236, 8'd238, 8'd239,
    8'd241, 8'd242, 8'd244, 8'd245, 8'd246, 8'd247, 8'd248, 8'd249, 8'd250,
    8'd251, 8'd251, 8'd252, 8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd254,
    8'd254, 8'd255
  };

  // Full 256-step sine lookup built from the quarter table by symmetry.
  function automatic logic [7:0] sine_rom(input logic [7:0] p);
    logic [7:0] idx;
    logic [7:0] res;
    idx = 8'd0;
    if (p == 8'd192) begin
      res = 8'd0;
    end else if (p <= 8'd64) begin
      idx = p;
      res = QUARTER_SINE[idx[6:0]];
    end else if (p < 8'd128) begin
      idx = 8'd128 - p;
      res = QUARTER_SINE[idx[6:0]];
    end else if (p <= 8'd192) begin
      idx = p - 8'd128;
      res = 8'd254 - QUARTER_SINE[idx[6:0]];
    end else begin
      idx = 8'd0 - p;
      res = 8'd254 - QUARTER_SINE[idx[6:0]];
    end
    return res;
  endfunction

endpackage

FILE: rtl/core/pwg_if.sv
// Valid/ready channel interfaces of the PWM waveform generator:
// the input item channel and the result channel. Depends on pwg_pkg.
interface pwg_in_if import pwg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [BYTE_W-1:0] command_byte;

  modport source (output valid, output op, output command_byte, input ready);
  modport sink   (input valid, input op, input command_byte, output ready);
endinterface

interface pwg_out_if import pwg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                pwm_level;
  logic [PWM_W-1:0]    sample_value;
  logic [7:0]          sample_position;
  logic [WAVE_W-1:0]   wave_kind;
  logic [FREQ_W-1:0]   frequency_hz;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output pwm_level, output sample_value,
                  output sample_position, output wave_kind, output frequency_hz,
                  output status, input ready);
  modport sink   (input valid, input pwm_level, input sample_value,
                  input sample_position, input wave_kind, input frequency_hz,
                  input status, output ready);
endinterface

FILE: rtl/core/pwm_waveform_generator_unit.sv
// PWM waveform generator, top level. Each input transaction is a timer tick
// or a command byte and yields one result transaction. A tick, a waveform
// select or an unknown byte is applied as it is accepted, and the block
// takes one such item every clock while each result is taken. A frequency
// step that takes effect runs the prescaler division in the datapath's
// restoring divider, one quotient bit per cycle, going through accept, divisor
// load, 8 division steps and limit write before the next item can enter. A
// result stays valid until it is taken, and no item enters while one waits untaken.
// Depends on pwg_pkg, pwg_if, pwg_datapath and pwg_controller.
module pwm_waveform_generator_unit import pwg_pkg::*; #(
  parameter int SAMPLES = SAMPLES_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  pwg_in_if.sink    cmd_ch,
  pwg_out_if.source res_ch
);

  pwg_cmd_t  cmd;
  pwg_stat_t stat;

  // Sequencing and handshakes.
  pwg_controller u_ctl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd_ch.valid),
    .in_ready  (cmd_ch.ready),
    .out_valid (res_ch.valid),
    .out_ready (res_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Counters, waveform samples and the divider.
  pwg_datapath #(
    .SAMPLES (SAMPLES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .op              (cmd_ch.op),
    .command_byte    (cmd_ch.command_byte),
    .pwm_level       (res_ch.pwm_level),
    .sample_value    (res_ch.sample_value),
    .sample_position (res_ch.sample_position),
    .wave_kind       (res_ch.wave_kind),
    .frequency_hz    (res_ch.frequency_hz),
    .status          (res_ch.status)
  );

endmodule

FILE: rtl/core/pwg_datapath.sv
// Datapath of the PWM waveform generator: counters, waveform sample
// generation, command decode and the restoring prescaler divider.
// Depends on pwg_pkg; driven by pwg_controller through pwg_cmd_t.
module pwg_datapath import pwg_pkg::*; #(
  parameter int SAMPLES = SAMPLES_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  pwg_cmd_t            cmd,
  output pwg_stat_t           stat,
  input  logic                op,
  input  logic [BYTE_W-1:0]   command_byte,
  output logic                pwm_level,
  output logic [PWM_W-1:0]    sample_value,
  output logic [7:0]          sample_position,
  output logic [WAVE_W-1:0]   wave_kind,
  output logic [FREQ_W-1:0]   frequency_hz,
  output logic [STATUS_W-1:0] status
);

  localparam int IDX_W = $clog2(SAMPLES);
  localparam int HALF  = SAMPLES / 2;
  localparam int ACC_W = 10;

  // Per-step increments of floor(i*M/SAMPLES) for M = 256, 512 and 255.
  localparam logic [ACC_W-1:0] Q256 = ACC_W'(256 / SAMPLES);
  localparam logic [IDX_W-1:0] R256 = IDX_W'(256 % SAMPLES);
  localparam logic [ACC_W-1:0] Q512 = ACC_W'(512 / SAMPLES);
  localparam logic [IDX_W-1:0] R512 = IDX_W'(512 % SAMPLES);
  localparam logic [ACC_W-1:0] Q255 = ACC_W'(255 / SAMPLES);
  localparam logic [IDX_W-1:0] R255 = IDX_W'(255 % SAMPLES);
  localparam logic [IDX_W:0]   S_EXT    = (IDX_W+1)'(SAMPLES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SAMPLES - 1);
  localparam logic [IDX_W-1:0] IDX_HALF = IDX_W'(HALF);

  // Divider widths: dividend is the timer clock, divisor SAMPLES*256*f.
  localparam int DIV_K = SAMPLES * (PWM_TOP + 1);
  localparam int DEN_W = $clog2(FREQ_MAX * DIV_K + 1);
  localparam int DIV_W = DEN_W + QUOT_W - 1;
  localparam int REM_W = $clog2(TIMER_CLOCK + 1);

  // Quotient/remainder pair that tracks floor(i*M/SAMPLES) as i steps.
  typedef struct packed {
    logic [ACC_W-1:0] q;
    logic [IDX_W-1:0] r;
  } acc_t;

  function automatic acc_t acc_advance(input acc_t a, input logic [ACC_W-1:0] q0,
                                       input logic [IDX_W-1:0] r0);
    logic [IDX_W:0] rs;
    acc_t o;
    rs = {1'b0, a.r} + {1'b0, r0};
    if (rs >= S_EXT) begin
      o.r = IDX_W'(rs - S_EXT);
      o.q = a.q + q0 + ACC_W'(1);
    end else begin
      o.r = rs[IDX_W-1:0];
      o.q = a.q + q0;
    end
    return o;
  endfunction

  // Architectural state.
  logic [WAVE_W-1:0]   wave_mode;
  logic [FREQ_W-1:0]   frequency_reg;
  logic [LIMIT_W-1:0]  prescale_limit;
  logic [LIMIT_W-1:0]  prescale_count;
  logic [PWM_W-1:0]    pwm_count;
  logic [IDX_W-1:0]    sample_index;
  logic [PWM_W-1:0]    compare_value;
  logic [STATUS_W-1:0] status_code;
  acc_t                acc256, acc512, acc255, acc512f;

  // Divider registers.
  logic [REM_W-1:0]  div_rem;
  logic [DIV_W-1:0]  div_den;
  logic [QUOT_W-1:0] div_quot;

  // Command decode.
  logic is_wave_cmd, is_up, is_down, up_ok, down_ok;
  logic [FREQ_W-1:0] freq_next;

  assign is_wave_cmd = (command_byte >= CMD_SINE) && (command_byte <= CMD_SAWTOOTH);
  assign is_up       = (command_byte == CMD_FREQ_UP);
  assign is_down     = (command_byte == CMD_FREQ_DN);
  assign up_ok       = frequency_reg < FREQ_W'(FREQ_MAX);
  assign down_ok     = frequency_reg > FREQ_W'(FREQ_MIN);
  assign freq_next   = is_up ? frequency_reg + FREQ_W'(FREQ_STEP)
                             : frequency_reg - FREQ_W'(FREQ_STEP);
  assign stat.freq_change = (op == OP_COMMAND) && ((is_up && up_ok) || (is_down && down_ok));

  // Tick path: prescale and PWM wraps, next sample index and accumulators.
  logic [LIMIT_W-1:0] prescale_inc;
  logic               prescale_wrap, pwm_wrap;
  logic [IDX_W-1:0]   index_next;
  acc_t               acc256_n, acc512_n, acc255_n, acc512f_n;
  logic [PWM_W-1:0]   sample_next;
  logic [ACC_W-1:0]   fall_value;

  assign prescale_inc  = prescale_count + LIMIT_W'(1);
  assign prescale_wrap = !(prescale_inc < prescale_limit);
  assign pwm_wrap      = (pwm_count >= PWM_W'(PWM_TOP));
  assign index_next    = (sample_index == IDX_LAST) ? '0 : sample_index + IDX_W'(1);

  always_comb begin
    if (index_next == '0) begin
      acc256_n  = '0;
      acc512_n  = '0;
      acc255_n  = '0;
      acc512f_n = '0;
    end else begin
      acc256_n  = acc_advance(acc256, Q256, R256);
      acc512_n  = acc_advance(acc512, Q512, R512);
      acc255_n  = acc_advance(acc255, Q255, R255);
      acc512f_n = (index_next == IDX_HALF) ? '0 : acc_advance(acc512f, Q512, R512);
    end
  end

  // Waveform sample at the next index for the current mode.
  assign fall_value = ACC_W'(255) - acc512f_n.q;

  always_comb begin
    case (wave_mode)
      SHAPE_SINE:     sample_next = sine_rom(acc256_n.q[7:0]);
      SHAPE_SQUARE:   sample_next = (index_next < IDX_HALF) ? 8'd255 : 8'd0;
      SHAPE_TRIANGLE: sample_next = (index_next < IDX_HALF) ? acc512_n.q[7:0]
                                                            : fall_value[7:0];
      SHAPE_RAMP:     sample_next = acc255_n.q[7:0];
      default:        sample_next = '0;
    endcase
  end

  // Divider step: one quotient bit per cycle, restoring form.
  logic [DIV_W-1:0] rem_ext;
  logic             div_fit;
  logic [DEN_W-1:0] den_base;

  assign rem_ext  = DIV_W'(div_rem);
  assign div_fit  = rem_ext >= div_den;
  assign den_base = DEN_W'(frequency_reg) * DEN_W'(DIV_K);

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      div_rem  <= REM_W'(TIMER_CLOCK);
      div_den  <= {den_base, {(QUOT_W-1){1'b0}}};
      div_quot <= '0;
    end else if (cmd.div_step) begin
      if (div_fit) begin
        div_rem <= REM_W'(rem_ext - div_den);
      end
      div_den  <= div_den >> 1;
      div_quot <= {div_quot[QUOT_W-2:0], div_fit};
    end
  end

  // State update.
  always_ff @(posedge clk) begin
    if (rst) begin
      wave_mode      <= SHAPE_SINE;
      frequency_reg  <= FREQ_W'(FREQ_RESET);
      prescale_limit <= LIMIT_W'(LIMIT_RESET);
      prescale_count <= '0;
      pwm_count      <= '0;
      sample_index   <= '0;
      compare_value  <= '0;
      status_code    <= STATUS_OK;
      acc256         <= '0;
      acc512         <= '0;
      acc255         <= '0;
      acc512f        <= '0;
    end else if (cmd.apply) begin
      status_code <= STATUS_OK;
      if (op == OP_TICK) begin
        if (!prescale_wrap) begin
          prescale_count <= prescale_inc;
        end else begin
          prescale_count <= '0;
          if (pwm_wrap) begin
            pwm_count     <= '0;
            sample_index  <= index_next;
            acc256        <= acc256_n;
            acc512        <= acc512_n;
            acc255        <= acc255_n;
            acc512f       <= acc512f_n;
            compare_value <= sample_next;
          end else begin
            pwm_count <= pwm_count + PWM_W'(1);
          end
        end
      end else if (is_wave_cmd) begin
        wave_mode <= WAVE_W'(command_byte - CMD_SINE);
      end else if (is_up || is_down) begin
        if (stat.freq_change) begin
          frequency_reg  <= freq_next;
          prescale_count <= '0;
          pwm_count      <= '0;
          sample_index   <= '0;
          compare_value  <= '0;
          acc256         <= '0;
          acc512         <= '0;
          acc255         <= '0;
          acc512f        <= '0;
        end else begin
          status_code <= STATUS_LIMIT;
        end
      end else begin
        status_code <= STATUS_UNKNOWN;
      end
    end else if (cmd.div_finish) begin
      // Saturate at the top; a zero quotient is raised to one.
      if (div_quot[QUOT_W-1]) begin
        prescale_limit <= LIMIT_W'(LIMIT_MAX);
      end else if (div_quot == '0) begin
        prescale_limit <= LIMIT_W'(1);
      end else begin
        prescale_limit <= div_quot[LIMIT_W-1:0];
      end
    end
  end

  // Result payload comes straight from the state registers.
  assign pwm_level       = pwm_count < compare_value;
  assign sample_value    = compare_value;
  assign sample_position = 8'(sample_index);
  assign wave_kind       = wave_mode;
  assign frequency_hz    = frequency_reg;
  assign status          = status_code;

  // The prescale limit never reaches zero.
  assert property (@(posedge clk) disable iff (rst) prescale_limit != '0)
    else $error("prescale limit is zero");

  // The sample index stays inside one period.
  assert property (@(posedge clk) disable iff (rst) sample_index <= IDX_LAST)
    else $error("sample index out of range");

  // The frequency stays inside its band.
  assert property (@(posedge clk) disable iff (rst)
    frequency_reg >= FREQ_W'(FREQ_MIN) && frequency_reg <= FREQ_W'(FREQ_MAX))
    else $error("frequency out of range");

endmodule

FILE: rtl/core/pwg_controller.sv
// Controller of the PWM waveform generator: input/output handshakes and
// the sequencing of the prescaler division. Depends on pwg_pkg.
module pwg_controller import pwg_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  pwg_stat_t stat,
  output pwg_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } ctl_state_t;

  ctl_state_t        state, state_next;
  logic [STEP_W-1:0] step_count;
  logic              accept;
  logic              out_valid_next;

  // An item enters only when idle and the result slot is free or emptying.
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  assign cmd.apply      = accept;
  assign cmd.div_load   = (state == S_LOAD);
  assign cmd.div_step   = (state == S_DIV);
  assign cmd.div_finish = (state == S_DONE);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && stat.freq_change) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: state_next = S_DIV;
      S_DIV: begin
        if (step_count == STEP_W'(QUOT_W - 1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Result valid flag: set by a finished transaction, cleared when taken.
  always_comb begin
    out_valid_next = out_valid && !out_ready;
    if ((accept && !stat.freq_change) || state == S_DONE) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      step_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      if (state == S_DIV) begin
        step_count <= step_count + STEP_W'(1);
      end else begin
        step_count <= '0;
      end
    end
  end

  // Ready is only offered from idle.
  assert property (@(posedge clk) disable iff (rst) in_ready |-> state == S_IDLE)
    else $error("ready outside idle");

  // The finishing cycle always posts a result.
  assert property (@(posedge clk) disable iff (rst) state == S_DONE |=> out_valid)
    else $error("division finished without a result");

  // The division runs exactly one step per quotient bit.
  assert property (@(posedge clk) disable iff (rst)
    state == S_DIV && step_count == STEP_W'(QUOT_W - 1) |=> state == S_DONE)
    else $error("division did not end after the last step");

endmodule
